@@ design/aspect_ratio_classifier_assert.svh @@
// Assertion macros shared by the classifier RTL.
// Each macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef ASPECT_RATIO_CLASSIFIER_ASSERT_SVH
`define ASPECT_RATIO_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

`define ARC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ARC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define ARC_ASSERT(lbl, prop)

`define ARC_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

@@ design/arc_pkg.sv @@
package arc_pkg;

    // Width of the generic function arguments; holds any legal DIM_BITS.
    localparam int MATCH_BITS  = 32;
    localparam int RATIO_COUNT = 13;

    typedef enum logic [3:0] {
        CLS_UNDEFINED = 4'd0,
        CLS_3_2       = 4'd1,
        CLS_4_3       = 4'd2,
        CLS_5_3       = 4'd3,
        CLS_5_4       = 4'd4,
        CLS_8_5       = 4'd5,
        CLS_16_9      = 4'd6,
        CLS_16_10     = 4'd7,
        CLS_21_9      = 4'd8,
        CLS_32_9      = 4'd9,
        CLS_37_27     = 4'd10,
        CLS_43_18     = 4'd11,
        CLS_64_27     = 4'd12,
        CLS_CUSTOM    = 4'd13
    } ratio_class_t;

    typedef struct packed {
        logic [9:0]   w;
        logic [9:0]   h;
        ratio_class_t cls;
    } ratio_entry_t;

    // 683:384 is an alternate form of 16:9; 16:10 and 21:9 never match a reduced pair.
    localparam ratio_entry_t KNOWN_RATIOS [RATIO_COUNT] = '{
        '{10'd3,   10'd2,   CLS_3_2},
        '{10'd4,   10'd3,   CLS_4_3},
        '{10'd5,   10'd3,   CLS_5_3},
        '{10'd5,   10'd4,   CLS_5_4},
        '{10'd8,   10'd5,   CLS_8_5},
        '{10'd16,  10'd9,   CLS_16_9},
        '{10'd683, 10'd384, CLS_16_9},
        '{10'd16,  10'd10,  CLS_16_10},
        '{10'd21,  10'd9,   CLS_21_9},
        '{10'd32,  10'd9,   CLS_32_9},
        '{10'd37,  10'd27,  CLS_37_27},
        '{10'd43,  10'd18,  CLS_43_18},
        '{10'd64,  10'd27,  CLS_64_27}
    };

    // Divider handshake between the sequencer and the shared unit.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Look up a reduced pair; scan downward so the first table entry wins.
    function automatic ratio_class_t arc_match(input logic [MATCH_BITS-1:0] wt,
                                               input logic [MATCH_BITS-1:0] ht);
        ratio_class_t cls;
        cls = CLS_CUSTOM;
        for (int i = RATIO_COUNT - 1; i >= 0; i--)
        begin
            if (wt == MATCH_BITS'(KNOWN_RATIOS[i].w) && ht == MATCH_BITS'(KNOWN_RATIOS[i].h))
            begin
                cls = KNOWN_RATIOS[i].cls;
            end
        end
        return cls;
    endfunction

endpackage

@@ design/arc_in_if.sv @@
interface arc_in_if #(
    parameter int DIM_BITS = 14
) ();
    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] width_px;
    logic [DIM_BITS-1:0] height_px;

    modport source (output valid, output width_px, output height_px, input ready);
    modport sink   (input valid, input width_px, input height_px, output ready);
endinterface

@@ design/arc_out_if.sv @@
interface arc_out_if #(
    parameter int DIM_BITS = 14
) ();
    logic                valid;
    logic                ready;
    logic [3:0]          ratio_class;
    logic [DIM_BITS-1:0] width_term;
    logic [DIM_BITS-1:0] height_term;

    modport source (output valid, output ratio_class, output width_term,
                    output height_term, input ready);
    modport sink   (input valid, input ratio_class, input width_term,
                    input height_term, output ready);
endinterface

@@ design/arc_div.sv @@
`include "aspect_ratio_classifier_assert.svh"

// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module arc_div
    import arc_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  div_ctl_t            ctl,
    input  logic [DIM_BITS-1:0] num,
    input  logic [DIM_BITS-1:0] den,
    output div_sts_t            sts,
    output logic [DIM_BITS-1:0] quo,
    output logic [DIM_BITS-1:0] rem
);

    localparam int CNT_BITS = $clog2(DIM_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIM_BITS-1:0] quo_reg, quo_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;
    logic [DIM_BITS-1:0] den_reg, den_next;

    logic [DIM_BITS:0]   shifted;
    logic [DIM_BITS:0]   diff;
    logic                fits;

    assign shifted = {rem_reg, quo_reg[DIM_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = ~diff[DIM_BITS];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in; keep the difference if it fits
            quo_next = {quo_reg[DIM_BITS-2:0], fits};
            rem_next = fits ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(DIM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;
    assign rem      = rem_reg;

    `ARC_ASSERT(start_sets_busy, ctl.start |=> (busy_reg && !done_reg))

endmodule

@@ design/arc_ctrl.sv @@
`include "aspect_ratio_classifier_assert.svh"

// Sequencer: Euclid remainder loop, then two divisions by the divisor found; a zero dimension skips both.
module arc_ctrl
    import arc_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    arc_in_if.sink              req,
    output div_ctl_t            ctl,
    output logic [DIM_BITS-1:0] num,
    output logic [DIM_BITS-1:0] den,
    input  div_sts_t            sts,
    input  logic [DIM_BITS-1:0] quo,
    input  logic [DIM_BITS-1:0] rem,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [DIM_BITS-1:0] res_wt,
    output logic [DIM_BITS-1:0] res_ht
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIVW = 5'b00100,
        S_DIVH = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic                start_reg, start_next;
    logic [DIM_BITS-1:0] w_reg, w_next;
    logic [DIM_BITS-1:0] h_reg, h_next;
    logic [DIM_BITS-1:0] a_reg, a_next;
    logic [DIM_BITS-1:0] b_reg, b_next;
    logic [DIM_BITS-1:0] wt_reg, wt_next;
    logic [DIM_BITS-1:0] ht_reg, ht_next;

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        w_next     = w_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        wt_next    = wt_reg;
        ht_next    = ht_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    w_next = req.width_px;
                    h_next = req.height_px;
                    if (req.width_px == '0 || req.height_px == '0)
                    begin
                        wt_next    = '0;
                        ht_next    = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        a_next     = req.width_px;
                        b_next     = req.height_px;
                        start_next = 1'b1;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (sts.done)
                begin
                    start_next = 1'b1;
                    if (rem == '0)
                    begin
                        // b holds the divisor from here on
                        a_next     = w_reg;
                        state_next = S_DIVW;
                    end
                    else
                    begin
                        a_next = b_reg;
                        b_next = rem;
                    end
                end
            end
            S_DIVW:
            begin
                if (sts.done)
                begin
                    wt_next    = quo;
                    a_next     = h_reg;
                    start_next = 1'b1;
                    state_next = S_DIVH;
                end
            end
            S_DIVH:
            begin
                if (sts.done)
                begin
                    ht_next    = quo;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        h_reg  <= h_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        wt_reg <= wt_next;
        ht_reg <= ht_next;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign ctl.start = start_reg;
    assign num       = a_reg;
    assign den       = b_reg;
    assign res_valid = (state_reg == S_EMIT);
    assign res_wt    = wt_reg;
    assign res_ht    = ht_reg;

    `ARC_ASSERT(start_when_free, ctl.start |-> !sts.busy)
    `ARC_ASSERT(accept_leaves_idle, (req.valid && req.ready) |=> (state_reg != S_IDLE))

endmodule

@@ design/aspect_ratio_classifier.sv @@
// Aspect ratio classifier.
// req carries one display size (width_px, height_px); rsp returns one result
// per request: ratio_class, and the width and height divided by their greatest
// common divisor. A zero dimension gives the undefined class with zero terms;
// a reduced pair not in the known list gives the custom class.
// Both channels transfer on a clock edge with valid and ready high.
// The request side takes one size at a time: req.ready is high only while the
// sequencer is idle. Euclid's loop and the two final divisions all run through
// one restoring divider that retires one quotient bit per cycle. The next
// request can transfer in the cycle after the result loads. A zero dimension
// skips the divider and goes straight to the result.
// The result waits in an output register; while rsp stalls the sequencer may
// finish the next request and then holds it until the register frees up.
// Reset clears the sequencer, the divider control and the output valid flag.
module aspect_ratio_classifier
    import arc_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic     clk,
    input  logic     rst_n,
    arc_in_if.sink   req,
    arc_out_if.source rsp
);

    div_ctl_t            ctl;
    div_sts_t            sts;
    logic [DIM_BITS-1:0] num;
    logic [DIM_BITS-1:0] den;
    logic [DIM_BITS-1:0] quo;
    logic [DIM_BITS-1:0] rem;
    logic                res_valid;
    logic                res_ready;
    logic [DIM_BITS-1:0] res_wt;
    logic [DIM_BITS-1:0] res_ht;

    // Output register
    logic                out_valid_reg, out_valid_next;
    ratio_class_t        class_reg, class_next;
    logic [DIM_BITS-1:0] wt_out_reg, wt_out_next;
    logic [DIM_BITS-1:0] ht_out_reg, ht_out_next;
    logic                load;

    arc_ctrl #(
        .DIM_BITS (DIM_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .num       (num),
        .den       (den),
        .sts       (sts),
        .quo       (quo),
        .rem       (rem),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_wt    (res_wt),
        .res_ht    (res_ht)
    );

    arc_div #(
        .DIM_BITS (DIM_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .num   (num),
        .den   (den),
        .sts   (sts),
        .quo   (quo),
        .rem   (rem)
    );

    // The register is free when empty or when its current result transfers now.
    assign res_ready = !out_valid_reg || rsp.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        class_next     = class_reg;
        wt_out_next    = wt_out_reg;
        ht_out_next    = ht_out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            wt_out_next    = res_wt;
            ht_out_next    = res_ht;
            // a zero width term only comes from a zero dimension
            if (res_wt == '0)
            begin
                class_next = CLS_UNDEFINED;
            end
            else
            begin
                class_next = arc_match(MATCH_BITS'(res_wt), MATCH_BITS'(res_ht));
            end
        end
        else if (rsp.ready)
        begin
            // drop the result once it has transferred
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg  <= class_next;
        wt_out_reg <= wt_out_next;
        ht_out_reg <= ht_out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ratio_class = class_reg;
    assign rsp.width_term  = wt_out_reg;
    assign rsp.height_term = ht_out_reg;

    `ARC_ASSERT_MSG(undefined_iff_zero,
        rsp.valid |-> ((class_reg == CLS_UNDEFINED) == (wt_out_reg == '0)),
        "undefined class and zero term disagree")

    `ARC_ASSERT_MSG(zero_terms_paired,
        rsp.valid |-> ((wt_out_reg == '0) == (ht_out_reg == '0)),
        "only one reduced term is zero")

endmodule

@@ tb/aspect_ratio_classifier_tb.sv @@
`timescale 1ns / 100ps

module aspect_ratio_classifier_tb;

    import arc_pkg::*;

    localparam int DIM         = 14;
    localparam int DIM_MAX     = (1 << DIM) - 1;
    localparam int QUIET_LIMIT = 3000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the pressure phase
    localparam int TAIL_CYCLES = 400;   // above the worst divider chain
    localparam int N_ROWS      = 25;

    // One reduced ratio as the block reports it.
    typedef struct packed {
        ratio_class_t   cls;
        logic [DIM-1:0] wt;
        logic [DIM-1:0] ht;
    } ratio_result_t;

    // Directed stimulus row; given marks rows whose answer is typed in below.
    typedef struct packed {
        logic [DIM-1:0] w;
        logic [DIM-1:0] h;
        bit             given;
        ratio_class_t   cls;
        logic [DIM-1:0] wt;
        logic [DIM-1:0] ht;
    } size_row_t;

    localparam size_row_t SIZE_ROWS [N_ROWS] = '{
        // zero in either dimension: undefined with zero terms
        '{14'd0,     14'd0,     1'b1, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd0,     14'd16383, 1'b1, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd16383, 14'd0,     1'b1, CLS_UNDEFINED, 14'd0,     14'd0},
        // extremes: square and one-pixel strips fall to custom
        '{14'd16383, 14'd16383, 1'b1, CLS_CUSTOM,    14'd1,     14'd1},
        '{14'd1,     14'd1,     1'b1, CLS_CUSTOM,    14'd1,     14'd1},
        '{14'd16383, 14'd1,     1'b1, CLS_CUSTOM,    14'd16383, 14'd1},
        '{14'd1,     14'd16383, 1'b1, CLS_CUSTOM,    14'd1,     14'd16383},
        // already-reduced list entries, including the alternate 16:9 form
        '{14'd3,     14'd2,     1'b1, CLS_3_2,       14'd3,     14'd2},
        '{14'd16,    14'd9,     1'b1, CLS_16_9,      14'd16,    14'd9},
        '{14'd683,   14'd384,   1'b1, CLS_16_9,      14'd683,   14'd384},
        // common display modes, covering every class a reduced pair can reach
        '{14'd1920,  14'd1080,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1366,  14'd768,   1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd2560,  14'd1080,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd3440,  14'd1440,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1680,  14'd1050,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1280,  14'd1024,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1024,  14'd768,   1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1280,  14'd768,   1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd2160,  14'd1440,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd5120,  14'd1440,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd2960,  14'd2160,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        // 21:9 marketing size reduces to 7:3, portrait 16:9 is custom
        '{14'd2520,  14'd1080,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd1080,  14'd1920,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        // longest remainder chain (consecutive Fibonacci) and a coprime pair
        '{14'd10946, 14'd6765,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0},
        '{14'd8192,  14'd8191,  1'b0, CLS_UNDEFINED, 14'd0,     14'd0}
    };

    // Known ratios used to build well-formed random sizes (16:10 and 21:9 too).
    localparam int GEN_W [13] = '{3, 4, 5, 5, 8, 16, 683, 16, 21, 32, 37, 43, 64};
    localparam int GEN_H [13] = '{2, 3, 3, 4, 5,  9, 384, 10,  9,  9, 27, 18, 27};

    logic clk = 1'b0;
    logic rst_n;

    arc_in_if  #(.DIM_BITS(DIM)) req_ch ();
    arc_out_if #(.DIM_BITS(DIM)) rsp_ch ();

    aspect_ratio_classifier #(
        .DIM_BITS (DIM)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ratio_result_t pending_ratios [$];  // expected results in transfer order
    bit            failed;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_req;
    int            quiet_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Reduce a size by Euclid's remainder loop and look the pair up.
    function automatic ratio_result_t reduce_ratio(input logic [DIM-1:0] w,
                                                   input logic [DIM-1:0] h);
        ratio_result_t res;
        int unsigned   a;
        int unsigned   b;
        int unsigned   r;
        res = '{CLS_UNDEFINED, '0, '0};
        if (w == '0 || h == '0)
        begin
            return res;
        end
        a = w;
        b = h;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        res.wt = DIM'(w / a);
        res.ht = DIM'(h / a);
        // 16:10 and 21:9 never survive reduction, so they get no entry here
        case ({res.wt, res.ht})
            {14'd3,   14'd2}:   res.cls = CLS_3_2;
            {14'd4,   14'd3}:   res.cls = CLS_4_3;
            {14'd5,   14'd3}:   res.cls = CLS_5_3;
            {14'd5,   14'd4}:   res.cls = CLS_5_4;
            {14'd8,   14'd5}:   res.cls = CLS_8_5;
            {14'd16,  14'd9}:   res.cls = CLS_16_9;
            {14'd683, 14'd384}: res.cls = CLS_16_9;
            {14'd32,  14'd9}:   res.cls = CLS_32_9;
            {14'd37,  14'd27}:  res.cls = CLS_37_27;
            {14'd43,  14'd18}:  res.cls = CLS_43_18;
            {14'd64,  14'd27}:  res.cls = CLS_64_27;
            default:            res.cls = CLS_CUSTOM;
        endcase
        return res;
    endfunction

    // Pick a random display size: zero dimensions, scaled known ratios, long
    // remainder chains, raw noise, or pairs with a random common factor.
    task automatic pick_size(output logic [DIM-1:0] w, output logic [DIM-1:0] h);
        int unsigned sel;
        int unsigned idx;
        int unsigned k;
        int unsigned g;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        logic [DIM-1:0] t;
        sel = $urandom_range(99);
        w = DIM'($urandom);
        h = DIM'($urandom);
        if (sel < 10)
        begin
            case ($urandom_range(2))
                0:       w = '0;
                1:       h = '0;
                default:
                begin
                    w = '0;
                    h = '0;
                end
            endcase
        end
        else if (sel < 45)
        begin
            idx = $urandom_range(12);
            a = GEN_W[idx];
            b = GEN_H[idx];
            k = $urandom_range(DIM_MAX / (a > b ? a : b), 1);
            w = DIM'(a * k);
            h = DIM'(b * k);
        end
        else if (sel < 55)
        begin
            // consecutive Fibonacci numbers: the longest remainder chains
            a = 1;
            b = 1;
            repeat ($urandom_range(19, 1))
            begin
                c = a + b;
                a = b;
                b = c;
            end
            w = DIM'(b);
            h = DIM'(a);
        end
        else if (sel >= 80)
        begin
            g = $urandom_range(256, 2);
            w = DIM'(g * $urandom_range(DIM_MAX / g, 1));
            h = DIM'(g * $urandom_range(DIM_MAX / g, 1));
        end
        // flip some to portrait so the custom path sees mirrored ratios
        if (sel >= 10 && $urandom_range(9) == 0)
        begin
            t = w;
            w = h;
            h = t;
        end
    endtask

    // Offer one size, with random idle cycles ahead of it, and hold it
    // until the block takes it; queue the expected answer on the transfer.
    task automatic send_size(input logic [DIM-1:0] w, input logic [DIM-1:0] h,
                             input ratio_result_t exp_r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.width_px  <= w;
        req_ch.height_px <= h;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        pending_ratios = {pending_ratios, exp_r};
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        logic [DIM-1:0] w;
        logic [DIM-1:0] h;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            pick_size(w, h);
            send_size(w, h, reduce_ratio(w, h));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        bit hold_done;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        ratio_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_ratios.size() == 0)
            begin
                failed = 1'b1;
                $display("%0t: unexpected result: class %0d terms %0d:%0d", $time,
                         rsp_ch.ratio_class, rsp_ch.width_term, rsp_ch.height_term);
            end
            else
            begin
                exp_r = pending_ratios.pop_front();
                if (rsp_ch.ratio_class !== exp_r.cls)
                begin
                    failed = 1'b1;
                    $display("%0t: ratio_class expected %0d actual %0d", $time,
                             exp_r.cls, rsp_ch.ratio_class);
                end
                if (rsp_ch.width_term !== exp_r.wt)
                begin
                    failed = 1'b1;
                    $display("%0t: width_term expected %0d actual %0d", $time,
                             exp_r.wt, rsp_ch.width_term);
                end
                if (rsp_ch.height_term !== exp_r.ht)
                begin
                    failed = 1'b1;
                    $display("%0t: height_term expected %0d actual %0d", $time,
                             exp_r.ht, rsp_ch.height_term);
                end
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        ratio_result_t exp_r;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.width_px  <= '0;
        req_ch.height_px <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling; typed-in answers where obvious.
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (SIZE_ROWS[i].given)
            begin
                exp_r = '{SIZE_ROWS[i].cls, SIZE_ROWS[i].wt, SIZE_ROWS[i].ht};
            end
            else
            begin
                exp_r = reduce_ratio(SIZE_ROWS[i].w, SIZE_ROWS[i].h);
            end
            send_size(SIZE_ROWS[i].w, SIZE_ROWS[i].h, exp_r);
        end

        // Random phases: free running, then back-pressure, then each side idling.
        run_random(450, 0, 0);
        // Hold the receiver off while the sender keeps offering back to back,
        // so the output register fills and the block stalls its input.
        hold_req = 1'b1;
        run_random(40, 0, 0);
        run_random(350, 48, 0);
        run_random(350, 0, 48);
        run_random(330, 19, 19);

        req_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_ratios.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (!failed)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
